// ----- rtl/core/ebnts_pkg.sv -----
package ebnts_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int MASS_W = 32;
    localparam int STEP_W = 16;
    localparam int ACC_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MASS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 2'd2;

    localparam logic [1:0] KIND_FORCE = 2'd0;
    localparam logic [1:0] KIND_ADDP  = 2'd1;
    localparam logic [1:0] KIND_ADDV  = 2'd2;
    localparam logic [1:0] KIND_OPP   = 2'd3;

    localparam logic [MASS_W-1:0] MASS_RST  = 32'd65536;
    localparam logic [STEP_W-1:0] STEP_RST  = 16'd1092;
    localparam logic [ACC_W-1:0]  ACCEL_RST = 32'd65536;

    typedef enum logic [1:0] {
        SER_IDLE,
        SER_RUN,
        SER_DONE
    } ser_state_t;

    // Opcode for the serial arithmetic unit.
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } ser_op_t;

    // Steps of the item sequencer in the top level.
    typedef enum logic [4:0] {
        ST_IDLE, ST_ADD, ST_DV_MUL, ST_DV_DIV, ST_DV_ADD, ST_DP_MUL, ST_DP_ADD,
        ST_SC_MX, ST_SC_MY, ST_SC_CMP, ST_FT, ST_F_SX, ST_F_SY, ST_F_SQRT,
        ST_F_M1, ST_F_M2, ST_F_DIV, ST_F_SAT, ST_OUT
    } main_state_t;

endpackage

// ----- rtl/core/euler_body_nearest_target_steer.sv -----
// Point body with Euler integration and nearest-opponent steering.
// Input stream s_axis_*: tdata holds vec_x then vec_y, tuser holds kind,
// tlast marks the final opponent of a scan (kind 3).
// Output stream m_axis_*: tdata holds pos_x, pos_y, vel_x, vel_y, force_x,
// force_y; tuser holds is_force. Kind 3 without tlast gives no transaction.
// Configuration: cfg_we, cfg_idx, cfg_data; write only while idle.
// Items are handled one at a time through one shared bit-serial unit of
// 128 bits that yields one result bit per cycle (the square root one bit
// per cycle as well). A force impulse runs one multiply and one divide
// per axis plus two multiplies; an opponent takes two multiplies; the
// final opponent adds two more multiplies, one root and per axis two
// multiplies and a divide.
// The result waits in the output register while the receiver stalls; the
// next input is taken once that register is free.
// Reset zeroes position and velocity, clears the scan and loads the
// default mass, step and acceleration.
module euler_body_nearest_target_steer #(
    parameter int FRAC_BITS = ebnts_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = ebnts_pkg::WORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // vec_x [W-1:0], vec_y [2W-1:W], padded to bytes
    input  logic [((2*WORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // kind [1:0]
    input  logic [1:0]                          s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, force_x, force_y from low bits up
    output logic [((6*WORD_BITS+7)/8)*8-1:0]    m_axis_tdata,
    // is_force [0]
    output logic                                m_axis_tuser,
    input  logic                                cfg_we,
    input  logic [ebnts_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [ebnts_pkg::MASS_W-1:0]        cfg_data
);

    localparam int W   = WORD_BITS;
    localparam int SW  = 128;
    localparam int IWB = ((2*W+7)/8)*8;
    localparam int OWB = ((6*W+7)/8)*8;
    localparam int KSH = (W > 32) ? 2*(W-32) : 0;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    ebnts_pkg::main_state_t state_reg, state_next;
    logic [ebnts_pkg::MASS_W-1:0] mass_reg;
    logic [ebnts_pkg::STEP_W-1:0] step_reg;
    logic [ebnts_pkg::ACC_W-1:0]  accel_reg;
    logic signed [W-1:0] px_reg, py_reg, vx_reg, vy_reg, fx_reg, fy_reg;
    logic signed [W-1:0] inx_reg, iny_reg, tx_reg, ty_reg, bx_reg, by_reg;
    logic [63:0]   best_reg;
    logic [1:0]    kind_reg;
    logic          last_reg, isf_reg, axis_reg, ovalid_reg;
    logic [SW-1:0] tmp_reg, sq_reg, len_reg;
    logic          start;
    ebnts_pkg::ser_op_t op;
    logic [SW-1:0] sa, sb, sres;
    logic          sdone, sbusy_reg;

    ebnts_serial #(.W(SW)) u_serial (
        .clk(clk), .rst_n(rst_n), .start(start), .op(op),
        .a(sa), .b(sb), .done(sdone), .result(sres)
    );

    function automatic logic signed [W-1:0] sat_add(logic signed [W-1:0] a,
                                                   logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_sub(logic signed [W-1:0] a,
                                                   logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic logic [SW-1:0] magn(logic signed [W-1:0] v);
        logic [W-1:0] m;
        m = v[W-1] ? (~v + 1'b1) : v;
        return SW'(m);
    endfunction

    function automatic logic signed [W-1:0] sat_mag(logic neg, logic [SW-1:0] m);
        logic [SW-1:0] lim;
        lim = SW'(1) << (W-1);
        if (!neg) return (m > lim - 1'b1) ? WMAX : W'(m);
        if (m > lim) return WMIN;
        return W'(~m + 1'b1);
    endfunction

    logic signed [W-1:0] cur_v, cur_t;
    assign cur_v = axis_reg ? vy_reg : vx_reg;
    assign cur_t = axis_reg ? ty_reg : tx_reg;
    logic signed [W-1:0] cur_in;
    assign cur_in = axis_reg ? iny_reg : inx_reg;
    logic [SW-1:0] key;
    assign key = (tmp_reg + sres) >> KSH;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg  <= ebnts_pkg::MASS_RST;
            step_reg  <= ebnts_pkg::STEP_RST;
            accel_reg <= ebnts_pkg::ACCEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                ebnts_pkg::REG_MASS:  mass_reg  <= cfg_data;
                ebnts_pkg::REG_STEP:  step_reg  <= cfg_data[ebnts_pkg::STEP_W-1:0];
                ebnts_pkg::REG_ACCEL: accel_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ebnts_pkg::ST_IDLE) && !ovalid_reg;

    // Serial unit launch control.
    always_comb
    begin
        start = 1'b0;
        op = ebnts_pkg::OP_MUL;
        sa = '0;
        sb = '0;
        case (state_reg)
            ebnts_pkg::ST_DV_MUL: begin sa = magn(cur_in); sb = SW'(step_reg); end
            ebnts_pkg::ST_DV_DIV:
            begin
                op = ebnts_pkg::OP_DIV;
                sa = tmp_reg << FRAC_BITS;
                sb = SW'(mass_reg) << 16;
            end
            ebnts_pkg::ST_DP_MUL: begin sa = magn(cur_v); sb = SW'(step_reg); end
            ebnts_pkg::ST_SC_MX:  begin sa = magn(tx_reg); sb = magn(tx_reg); end
            ebnts_pkg::ST_SC_MY:  begin sa = magn(ty_reg); sb = magn(ty_reg); end
            ebnts_pkg::ST_F_SX:   begin sa = magn(tx_reg); sb = magn(tx_reg); end
            ebnts_pkg::ST_F_SY:   begin sa = magn(ty_reg); sb = magn(ty_reg); end
            ebnts_pkg::ST_F_SQRT: begin op = ebnts_pkg::OP_SQRT; sa = sq_reg << 32; end
            ebnts_pkg::ST_F_M1:   begin sa = magn(cur_t); sb = SW'(accel_reg); end
            ebnts_pkg::ST_F_M2:   begin sa = tmp_reg; sb = SW'(mass_reg); end
            ebnts_pkg::ST_F_DIV:
            begin
                op = ebnts_pkg::OP_DIV;
                sa = tmp_reg << 16;
                sb = len_reg;
            end
            default: ;
        endcase
        start = !sbusy_reg && (state_reg inside {
                ebnts_pkg::ST_DV_MUL, ebnts_pkg::ST_DV_DIV, ebnts_pkg::ST_DP_MUL,
                ebnts_pkg::ST_SC_MX, ebnts_pkg::ST_SC_MY, ebnts_pkg::ST_F_SX,
                ebnts_pkg::ST_F_SY, ebnts_pkg::ST_F_SQRT, ebnts_pkg::ST_F_M1,
                ebnts_pkg::ST_F_M2, ebnts_pkg::ST_F_DIV});
        // A zero numerator skips the divide.
        if (state_reg == ebnts_pkg::ST_DV_DIV && tmp_reg == '0)
        begin
            start = 1'b0;
        end
        // A zero-length direction skips the root and the force.
        if (state_reg == ebnts_pkg::ST_F_SQRT && sq_reg == '0)
        begin
            start = 1'b0;
        end
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ebnts_pkg::ST_IDLE;
            sbusy_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            px_reg <= '0; py_reg <= '0; vx_reg <= '0; vy_reg <= '0;
            best_reg <= '1; bx_reg <= '0; by_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start) sbusy_reg <= 1'b1;
            else if (sdone) sbusy_reg <= 1'b0;
            if (state_reg == ebnts_pkg::ST_OUT) ovalid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) ovalid_reg <= 1'b0;
            case (state_reg)
                ebnts_pkg::ST_ADD:
                begin
                    if (kind_reg == ebnts_pkg::KIND_ADDP)
                    begin
                        px_reg <= sat_add(px_reg, inx_reg);
                        py_reg <= sat_add(py_reg, iny_reg);
                    end
                    else
                    begin
                        vx_reg <= sat_add(vx_reg, inx_reg);
                        vy_reg <= sat_add(vy_reg, iny_reg);
                    end
                end
                ebnts_pkg::ST_DV_ADD:
                begin
                    if (axis_reg) vy_reg <= sat_add(vy_reg, tx_reg);
                    else vx_reg <= sat_add(vx_reg, tx_reg);
                end
                ebnts_pkg::ST_DP_ADD:
                begin
                    if (axis_reg) py_reg <= sat_add(py_reg, tx_reg);
                    else px_reg <= sat_add(px_reg, tx_reg);
                end
                ebnts_pkg::ST_SC_CMP:
                begin
                    if (key[63:0] < best_reg)
                    begin
                        best_reg <= key[63:0];
                        bx_reg <= inx_reg;
                        by_reg <= iny_reg;
                    end
                end
                ebnts_pkg::ST_FT:
                begin
                    // The target is taken this cycle, so the scan starts afresh.
                    best_reg <= '1; bx_reg <= '0; by_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ebnts_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    inx_reg  <= s_axis_tdata[W-1:0];
                    iny_reg  <= s_axis_tdata[2*W-1:W];
                    kind_reg <= s_axis_tuser;
                    last_reg <= s_axis_tlast;
                    axis_reg <= 1'b0;
                    fx_reg <= '0; fy_reg <= '0; isf_reg <= 1'b0;
                    tx_reg <= sat_sub(s_axis_tdata[W-1:0], px_reg);
                    ty_reg <= sat_sub(s_axis_tdata[2*W-1:W], py_reg);
                end
            end
            ebnts_pkg::ST_DV_MUL: if (sdone) tmp_reg <= sres;
            ebnts_pkg::ST_DV_DIV:
            begin
                if (tmp_reg == '0) tx_reg <= '0;
                else if (sdone) tx_reg <= sat_mag(cur_in[W-1], sres);
            end
            ebnts_pkg::ST_DV_ADD: axis_reg <= !axis_reg;
            ebnts_pkg::ST_DP_MUL: if (sdone) tx_reg <= sat_mag(cur_v[W-1], sres >> 16);
            ebnts_pkg::ST_DP_ADD: axis_reg <= !axis_reg;
            ebnts_pkg::ST_SC_MX:  if (sdone) tmp_reg <= sres;
            ebnts_pkg::ST_FT:
            begin
                tx_reg <= sat_sub(bx_reg, px_reg);
                ty_reg <= sat_sub(by_reg, py_reg);
                axis_reg <= 1'b0;
                isf_reg <= 1'b1;
            end
            ebnts_pkg::ST_F_SX:   if (sdone) tmp_reg <= sres;
            ebnts_pkg::ST_F_SY:   if (sdone) sq_reg <= tmp_reg + sres;
            ebnts_pkg::ST_F_SQRT: if (sdone) len_reg <= sres;
            ebnts_pkg::ST_F_M1:   if (sdone) tmp_reg <= sres;
            ebnts_pkg::ST_F_M2:   if (sdone) tmp_reg <= sres;
            ebnts_pkg::ST_F_DIV:  if (sdone) tmp_reg <= sres >> FRAC_BITS;
            ebnts_pkg::ST_F_SAT:
            begin
                if (axis_reg) fy_reg <= sat_mag(cur_t[W-1], tmp_reg);
                else fx_reg <= sat_mag(cur_t[W-1], tmp_reg);
                axis_reg <= !axis_reg;
            end
            default: ;
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ebnts_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    case (s_axis_tuser)
                        ebnts_pkg::KIND_FORCE: state_next = ebnts_pkg::ST_DV_MUL;
                        ebnts_pkg::KIND_OPP:   state_next = ebnts_pkg::ST_SC_MX;
                        default:               state_next = ebnts_pkg::ST_ADD;
                    endcase
                end
            end
            ebnts_pkg::ST_ADD:    state_next = ebnts_pkg::ST_OUT;
            ebnts_pkg::ST_DV_MUL: if (sdone) state_next = ebnts_pkg::ST_DV_DIV;
            ebnts_pkg::ST_DV_DIV:
            begin
                if (sdone || tmp_reg == '0) state_next = ebnts_pkg::ST_DV_ADD;
            end
            ebnts_pkg::ST_DV_ADD:
            begin
                state_next = axis_reg ? ebnts_pkg::ST_DP_MUL : ebnts_pkg::ST_DV_MUL;
            end
            ebnts_pkg::ST_DP_MUL: if (sdone) state_next = ebnts_pkg::ST_DP_ADD;
            ebnts_pkg::ST_DP_ADD:
            begin
                state_next = axis_reg ? ebnts_pkg::ST_OUT : ebnts_pkg::ST_DP_MUL;
            end
            ebnts_pkg::ST_SC_MX:  if (sdone) state_next = ebnts_pkg::ST_SC_MY;
            ebnts_pkg::ST_SC_MY:  if (sdone) state_next = ebnts_pkg::ST_SC_CMP;
            ebnts_pkg::ST_SC_CMP:
            begin
                state_next = last_reg ? ebnts_pkg::ST_FT : ebnts_pkg::ST_IDLE;
            end
            ebnts_pkg::ST_FT:     state_next = ebnts_pkg::ST_F_SX;
            ebnts_pkg::ST_F_SX:   if (sdone) state_next = ebnts_pkg::ST_F_SY;
            ebnts_pkg::ST_F_SY:   if (sdone) state_next = ebnts_pkg::ST_F_SQRT;
            ebnts_pkg::ST_F_SQRT:
            begin
                if (sq_reg == '0) state_next = ebnts_pkg::ST_OUT;
                else if (sdone) state_next = ebnts_pkg::ST_F_M1;
            end
            ebnts_pkg::ST_F_M1:   if (sdone) state_next = ebnts_pkg::ST_F_M2;
            ebnts_pkg::ST_F_M2:   if (sdone) state_next = ebnts_pkg::ST_F_DIV;
            ebnts_pkg::ST_F_DIV:  if (sdone) state_next = ebnts_pkg::ST_F_SAT;
            ebnts_pkg::ST_F_SAT:
            begin
                state_next = axis_reg ? ebnts_pkg::ST_OUT : ebnts_pkg::ST_F_M1;
            end
            ebnts_pkg::ST_OUT:    state_next = ebnts_pkg::ST_IDLE;
            default:              state_next = ebnts_pkg::ST_IDLE;
        endcase
    end

    // Output register, loaded once per result.
    always_ff @(posedge clk)
    begin
        if (state_reg == ebnts_pkg::ST_OUT)
        begin
            m_axis_tdata <= OWB'({fy_reg, fx_reg, vy_reg, vx_reg, py_reg, px_reg});
            m_axis_tuser <= isf_reg;
        end
    end

    assign m_axis_tvalid = ovalid_reg;

    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[IWB-1:2*W-1];

endmodule

// ----- rtl/core/ebnts_serial.sv -----
// Shared bit-serial unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one result bit per cycle.
module ebnts_serial #(
    parameter int W = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ebnts_pkg::ser_op_t  op,
    input  logic [W-1:0]        a,
    input  logic [W-1:0]        b,
    output logic                done,
    output logic [W-1:0]        result
);

    localparam int CW = $clog2(W + 1);

    ebnts_pkg::ser_state_t state_reg, state_next;
    ebnts_pkg::ser_op_t    op_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  sh_reg, sh_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  opb_reg;
    logic [W:0]    trial;
    logic [W:0]    rem_sh;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ebnts_pkg::SER_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        if (start)
        begin
            op_reg  <= op;
            opb_reg <= b;
        end
    end

    // One step per cycle of the chosen recurrence.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        trial      = '0;
        rem_sh     = '0;
        case (state_reg)
            ebnts_pkg::SER_IDLE:
            begin
                if (start)
                begin
                    state_next = ebnts_pkg::SER_RUN;
                    acc_next   = '0;
                    rem_next   = '0;
                    sh_next    = a;
                    cnt_next   = (op == ebnts_pkg::OP_SQRT) ? CW'(W / 2) : CW'(W);
                end
            end
            ebnts_pkg::SER_RUN:
            begin
                case (op_reg)
                    ebnts_pkg::OP_MUL:
                    begin
                        // Multiplier bits taken from the top down.
                        acc_next = {acc_reg[W-2:0], 1'b0} + (sh_reg[W-1] ? opb_reg : '0);
                        sh_next  = {sh_reg[W-2:0], 1'b0};
                    end
                    ebnts_pkg::OP_DIV:
                    begin
                        rem_sh = {rem_reg[W-1:0], sh_reg[W-1]};
                        trial  = rem_sh - {1'b0, opb_reg};
                        sh_next = {sh_reg[W-2:0], 1'b0};
                        if (!trial[W])
                        begin
                            rem_next = trial;
                            acc_next = {acc_reg[W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next = rem_sh;
                            acc_next = {acc_reg[W-2:0], 1'b0};
                        end
                    end
                    default:
                    begin
                        // Two radicand bits in, one root bit out.
                        rem_sh = {rem_reg[W-2:0], sh_reg[W-1:W-2]};
                        trial  = rem_sh - {1'b0, acc_reg[W-3:0], 2'b01};
                        sh_next = {sh_reg[W-3:0], 2'b00};
                        if (!trial[W])
                        begin
                            rem_next = trial;
                            acc_next = {acc_reg[W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next = rem_sh;
                            acc_next = {acc_reg[W-2:0], 1'b0};
                        end
                    end
                endcase
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = ebnts_pkg::SER_DONE;
                end
            end
            ebnts_pkg::SER_DONE:
            begin
                state_next = ebnts_pkg::SER_IDLE;
            end
            default:
            begin
                state_next = ebnts_pkg::SER_IDLE;
            end
        endcase
    end

    assign done   = (state_reg == ebnts_pkg::SER_DONE);
    assign result = acc_reg;

endmodule

// ----- rtl/core/ebnts_checker.sv -----
module ebnts_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tuser
);

    // A result waiting for the receiver holds its valid.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A result waiting for the receiver keeps its kind.
    a_user: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser))
        else $error("result kind changed while stalled");

    // No input is taken while a result is still waiting.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken with result pending");

    // An accepted input is never followed at once by another.
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("two inputs in back-to-back cycles");

    // A result never appears the cycle after an input is taken.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");

endmodule

bind euler_body_nearest_target_steer ebnts_checker u_ebnts_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser)
);
